// ===== sv/chpf_pkg.sv =====
// Shared types and constants for the column histogram peak finder.
// No dependencies; every other file of the block but chpf_ram imports this package.
`timescale 1ns / 1ps

package chpf_pkg;

    // Frame geometry
    localparam int FRAME_COLUMNS = 1280;
    localparam int MAX_ROWS      = 720;

    // Field widths fixed by the interface
    localparam int PIX_W   = 8;
    localparam int COL_W   = 11;
    localparam int PEAK_W  = 10;

    // Internal widths derived from the geometry
    localparam int ADDR_W  = $clog2(FRAME_COLUMNS);
    localparam int CNT_W   = $clog2(MAX_ROWS + 1);

    // Configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 11;
    localparam logic [CFG_IDX_W-1:0] REG_MATCH_VALUE  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SPLIT_COLUMN = 1'd1;
    localparam logic [PIX_W-1:0]     MATCH_VALUE_RST  = 8'd255;
    localparam logic [COL_W-1:0]     SPLIT_COLUMN_RST = 11'd640;

    // Operation queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    typedef struct packed {
        logic [PIX_W-1:0] pixel_value;
        logic [COL_W-1:0] column;
        logic             frame_end;
    } t_in_item;

    typedef struct packed {
        logic [COL_W-1:0]  left_column;
        logic [COL_W-1:0]  right_column;
        logic [PEAK_W-1:0] left_peak;
        logic [PEAK_W-1:0] right_peak;
    } t_out_item;

    // One queued operation: count a pixel, start a peak scan, or both
    typedef struct packed {
        logic              inc;
        logic              scan;
        logic [ADDR_W-1:0] addr;
    } t_op;

    // Status from back to front
    typedef struct packed {
        logic clearing;
    } t_back_stat;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_INC_RD,
        ST_INC_WR,
        ST_SCAN,
        ST_SCAN_LAST,
        ST_OUT
    } t_back_state;

endpackage

// ===== sv/chpf_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps

module chpf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/chpf_front.sv =====
// Front end: accepts pixel transfers, classifies them and queues operations.
// Depends on chpf_pkg.
`timescale 1ns / 1ps

module chpf_front (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  chpf_pkg::t_in_item         i_data,
    input  logic [chpf_pkg::PIX_W-1:0] i_match_value,
    input  chpf_pkg::t_back_stat       i_stat,
    output logic                       o_op_valid,
    output chpf_pkg::t_op              o_op,
    input  logic                       i_op_ready
);
    import chpf_pkg::*;

    t_op                r_q [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  r_wr_ptr;
    logic [QPTR_W-1:0]  r_rd_ptr;
    logic [QPTR_W:0]    r_count;
    logic               accept;
    logic               push;
    logic               pop;
    logic               in_range;
    t_op                new_op;

    // Hold off input while the histogram memory is being swept after reset
    assign o_ready = !i_stat.clearing && (r_count != (QPTR_W+1)'(QUEUE_DEPTH));
    assign accept  = i_valid && o_ready;

    always_comb begin
        in_range    = 32'(i_data.column) < FRAME_COLUMNS;
        new_op.inc  = in_range && (i_data.pixel_value == i_match_value);
        new_op.scan = i_data.frame_end;
        new_op.addr = ADDR_W'(i_data.column);
    end

    // Drop transfers that neither count nor end the frame
    assign push       = accept && (new_op.inc || new_op.scan);
    assign o_op_valid = (r_count != '0);
    assign o_op       = r_q[r_rd_ptr];
    assign pop        = o_op_valid && i_op_ready;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr_ptr] <= new_op;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// ===== sv/chpf_back.sv =====
// Back end: updates the column histogram, runs the peak scan and holds the result.
// Depends on chpf_pkg and chpf_ram.
`timescale 1ns / 1ps

module chpf_back (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_op_valid,
    input  chpf_pkg::t_op                   i_op,
    output logic                            o_op_ready,
    input  logic [chpf_pkg::COL_W-1:0]      i_split_column,
    output chpf_pkg::t_back_stat            o_stat,
    output logic                            o_valid,
    input  logic                            i_ready,
    output chpf_pkg::t_out_item             o_data
);
    import chpf_pkg::*;

    t_back_state        r_state, n_state;
    t_op                r_op, n_op;
    logic [ADDR_W-1:0]  r_addr, n_addr;
    logic               r_pend, n_pend;
    logic [ADDR_W-1:0]  r_pend_col, n_pend_col;
    logic [CNT_W-1:0]   r_lcnt, n_lcnt;
    logic [ADDR_W-1:0]  r_lcol, n_lcol;
    logic [CNT_W-1:0]   r_rcnt, n_rcnt;
    logic [ADDR_W-1:0]  r_rcol, n_rcol;
    logic               r_out_vld, n_out_vld;
    t_out_item          r_out, n_out;

    logic               ram_we;
    logic [ADDR_W-1:0]  ram_waddr;
    logic [CNT_W-1:0]   ram_wdata;
    logic [ADDR_W-1:0]  ram_raddr;
    logic [CNT_W-1:0]   ram_rdata;
    logic               is_left;

    chpf_ram #(
        .WIDTH (CNT_W),
        .DEPTH (FRAME_COLUMNS)
    ) u_hist (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign is_left = 32'(r_pend_col) < 32'(i_split_column);

    always_comb begin
        n_state    = r_state;
        n_op       = r_op;
        n_addr     = r_addr;
        n_pend     = r_pend;
        n_pend_col = r_pend_col;
        n_lcnt     = r_lcnt;
        n_lcol     = r_lcol;
        n_rcnt     = r_rcnt;
        n_rcol     = r_rcol;
        n_out_vld  = r_out_vld;
        n_out      = r_out;
        ram_we     = 1'b0;
        ram_waddr  = r_addr;
        ram_wdata  = '0;
        ram_raddr  = r_addr;
        o_op_ready = 1'b0;

        // Result register empties on its own transfer
        if (r_out_vld && i_ready) begin
            n_out_vld = 1'b0;
        end

        // Fold the column read last cycle into the best-of-half trackers,
        // then zero it for the next frame
        if ((r_state == ST_SCAN || r_state == ST_SCAN_LAST) && r_pend) begin
            ram_we    = 1'b1;
            ram_waddr = r_pend_col;
            ram_wdata = '0;
            if (is_left) begin
                if (ram_rdata >= r_lcnt) begin
                    n_lcnt = ram_rdata;
                    n_lcol = r_pend_col;
                end
            end else begin
                if (ram_rdata >= r_rcnt) begin
                    n_rcnt = ram_rdata;
                    n_rcol = r_pend_col;
                end
            end
        end

        case (r_state)
            ST_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_addr;
                n_addr    = r_addr + 1'b1;
                if (r_addr == ADDR_W'(FRAME_COLUMNS - 1)) begin
                    n_addr  = '0;
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                o_op_ready = 1'b1;
                if (i_op_valid) begin
                    n_op = i_op;
                    if (i_op.inc) begin
                        n_state = ST_INC_RD;
                    end else begin
                        n_state = ST_SCAN;
                        n_addr  = '0;
                        n_pend  = 1'b0;
                        n_lcnt  = '0;
                        n_lcol  = '0;
                        n_rcnt  = '0;
                        n_rcol  = ADDR_W'(FRAME_COLUMNS - 1);
                    end
                end
            end
            ST_INC_RD: begin
                ram_raddr = r_op.addr;
                n_state   = ST_INC_WR;
            end
            ST_INC_WR: begin
                ram_we    = 1'b1;
                ram_waddr = r_op.addr;
                if (ram_rdata < CNT_W'(MAX_ROWS)) begin
                    ram_wdata = ram_rdata + 1'b1;
                end else begin
                    ram_wdata = ram_rdata;
                end
                if (r_op.scan) begin
                    n_state = ST_SCAN;
                    n_addr  = '0;
                    n_pend  = 1'b0;
                    n_lcnt  = '0;
                    n_lcol  = '0;
                    n_rcnt  = '0;
                    n_rcol  = ADDR_W'(FRAME_COLUMNS - 1);
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_SCAN: begin
                ram_raddr  = r_addr;
                n_pend     = 1'b1;
                n_pend_col = r_addr;
                n_addr     = r_addr + 1'b1;
                if (r_addr == ADDR_W'(FRAME_COLUMNS - 1)) begin
                    n_addr  = '0;
                    n_state = ST_SCAN_LAST;
                end
            end
            ST_SCAN_LAST: begin
                n_pend  = 1'b0;
                n_state = ST_OUT;
            end
            ST_OUT: begin
                if (!r_out_vld || i_ready) begin
                    n_out_vld          = 1'b1;
                    n_out.left_column  = COL_W'(r_lcol);
                    n_out.right_column = COL_W'(r_rcol);
                    n_out.left_peak    = PEAK_W'(r_lcnt);
                    n_out.right_peak   = PEAK_W'(r_rcnt);
                    n_state            = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_CLEAR;
            r_addr    <= '0;
            r_pend    <= 1'b0;
            r_out_vld <= 1'b0;
            r_lcnt    <= '0;
            r_lcol    <= '0;
            r_rcnt    <= '0;
            r_rcol    <= ADDR_W'(FRAME_COLUMNS - 1);
        end else begin
            r_state   <= n_state;
            r_addr    <= n_addr;
            r_pend    <= n_pend;
            r_out_vld <= n_out_vld;
            r_lcnt    <= n_lcnt;
            r_lcol    <= n_lcol;
            r_rcnt    <= n_rcnt;
            r_rcol    <= n_rcol;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op       <= n_op;
        r_pend_col <= n_pend_col;
        r_out      <= n_out;
    end

    assign o_stat.clearing = (r_state == ST_CLEAR);
    assign o_valid         = r_out_vld;
    assign o_data          = r_out;

endmodule

// ===== sv/column_histogram_peak_finder.sv =====
// Column histogram peak finder: per-column lane-pixel counts with a two-half peak scan.
// A counted pixel passes the back end as a RAM read then a write; a frame end adds a scan
// of every column through the histogram RAM port, then a load of the result register.
// Throughput: one pixel per cycle into a 4-deep queue while it has room; counted pixels
// drain one at a time by RAM read-modify-write. After reset a sweep of all FRAME_COLUMNS
// (1280) entries zeroes the histogram; input ready stays low until it is done.
`timescale 1ns / 1ps

module column_histogram_peak_finder (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // Pixel input
    input  logic                            i_valid,
    output logic                            o_ready,
    input  chpf_pkg::t_in_item              i_data,
    // Peak result
    output logic                            o_valid,
    input  logic                            i_ready,
    output chpf_pkg::t_out_item             o_data,
    // Configuration writes
    input  logic                            i_cfg_we,
    input  logic [chpf_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [chpf_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import chpf_pkg::*;

    logic [PIX_W-1:0] r_match_value;
    logic [COL_W-1:0] r_split_column;
    logic             op_valid;
    logic             op_ready;
    t_op              op;
    t_back_stat       stat;

    // Configuration registers: the user must write them only while the block is idle; the block does not enforce it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_match_value  <= MATCH_VALUE_RST;
            r_split_column <= SPLIT_COLUMN_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_MATCH_VALUE:  r_match_value  <= PIX_W'(i_cfg_data);
                REG_SPLIT_COLUMN: r_split_column <= COL_W'(i_cfg_data);
                default: begin
                end
            endcase
        end
    end

    // Front: classify each pixel transfer, queue counting and scan operations
    chpf_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_data        (i_data),
        .i_match_value (r_match_value),
        .i_stat        (stat),
        .o_op_valid    (op_valid),
        .o_op          (op),
        .i_op_ready    (op_ready)
    );

    // Back: histogram RAM update, scan with clear-behind, result register
    chpf_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_op_valid     (op_valid),
        .i_op           (op),
        .o_op_ready     (op_ready),
        .i_split_column (r_split_column),
        .o_stat         (stat),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_data         (o_data)
    );

endmodule

// ===== tb/sv/tb.sv =====
// Self-checking testbench for column_histogram_peak_finder: directed table, then random frames.
// Depends on chpf_pkg (item types, register indexes, geometry) and the block's top module.
`timescale 1ns / 1ps

module tb;
    import chpf_pkg::*;

    localparam int CLK_PERIOD    = 10;
    localparam int RESET_CYCLES  = 9;
    localparam int LIMIT_CYCLES  = 5_000_000;  // several times the slowest correct run
    localparam int DRAIN_LIMIT   = 50_000;     // cycles to wait for pending peak results
    localparam int SETTLE_CYCLES = 64;         // quiet time after the last result
    localparam int HOLD_CYCLES   = 6000;       // long receiver hold-off
    localparam int PHASE_ITEMS   = 165;
    localparam int PHASE_FRAMES  = 12;

    typedef enum logic [1:0] {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } t_idle_mode;

    typedef enum logic [0:0] {
        ROW_PIXEL,
        ROW_WRITE
    } t_row_kind;

    typedef struct packed {
        t_row_kind                kind;
        t_in_item                 item;
        logic                     typed;
        t_out_item                want;
        logic [CFG_IDX_W-1:0]     reg_index;
        logic [CFG_DATA_W-1:0]    reg_data;
    } t_stim_row;

    // Block inputs, all known from time zero
    logic                  i_clk       = 1'b0;
    logic                  r_rst_n     = 1'b0;
    logic                  r_valid     = 1'b0;
    t_in_item              r_in_item   = '0;
    logic                  r_ready     = 1'b0;
    logic                  r_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  r_cfg_index = '0;
    logic [CFG_DATA_W-1:0] r_cfg_data  = '0;

    logic      o_ready;
    logic      o_valid;
    t_out_item o_data;

    column_histogram_peak_finder i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (r_rst_n),
        .i_valid     (r_valid),
        .o_ready     (o_ready),
        .i_data      (r_in_item),
        .o_valid     (o_valid),
        .i_ready     (r_ready),
        .o_data      (o_data),
        .i_cfg_we    (r_cfg_we),
        .i_cfg_index (r_cfg_index),
        .i_cfg_data  (r_cfg_data)
    );

    // Predictor state: its own histogram and register copies
    bit   [CNT_W-1:0] lane_hist [FRAME_COLUMNS];
    logic [PIX_W-1:0] cur_match = MATCH_VALUE_RST;
    logic [COL_W-1:0] cur_split = SPLIT_COLUMN_RST;

    t_out_item  peak_expect_q [$];
    t_stim_row  stim_rows [$];

    t_idle_mode run_mode   = IDLE_NONE;
    bit         hold_req   = 1'b0;
    bit         hold_taken = 1'b0;
    int         hold_left  = 0;

    int mismatch_count = 0;
    int pixels_sent    = 0;
    int frames_sent    = 0;
    int results_seen   = 0;

    initial begin
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    // Hard stop in case the block hangs
    initial begin
        #(longint'(LIMIT_CYCLES) * CLK_PERIOD);
        $display("timeout after %0d cycles", LIMIT_CYCLES);
        $display("end of test: mismatches");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        $display("[%0t] MISMATCH: %s", $time, msg);
        mismatch_count++;
    endtask

    // Percent of cycles in which a side idles under the given mode
    function automatic int idle_pct(input t_idle_mode m, input bit sender);
        case (m)
            IDLE_NONE:     return 0;
            IDLE_SENDER:   return sender ? 59 : 0;
            IDLE_RECEIVER: return sender ? 0 : 59;
            default:       return 19;
        endcase
    endfunction

    // Count one pixel into the model histogram; on frame end scan both halves,
    // hand back the peaks and clear the histogram.
    function automatic bit predict_peaks(input t_in_item it, output t_out_item res);
        int c;
        int hi;
        int best;
        int bcol;
        res = '0;
        if (it.column < FRAME_COLUMNS && it.pixel_value == cur_match) begin
            if (lane_hist[it.column] < MAX_ROWS) lane_hist[it.column]++;
        end
        if (!it.frame_end) return 1'b0;

        // Left half [0, split): ties go to the higher column, empty half gives column 0
        hi   = (cur_split > FRAME_COLUMNS) ? FRAME_COLUMNS : cur_split;
        best = 0;
        bcol = 0;
        for (c = 0; c < hi; c++) begin
            if (lane_hist[c] >= best) begin
                best = lane_hist[c];
                bcol = c;
            end
        end
        res.left_column = COL_W'(bcol);
        res.left_peak   = PEAK_W'(best);

        // Right half [split, FRAME_COLUMNS): empty half gives the last column
        best = 0;
        bcol = FRAME_COLUMNS - 1;
        for (c = cur_split; c < FRAME_COLUMNS; c++) begin
            if (lane_hist[c] >= best) begin
                best = lane_hist[c];
                bcol = c;
            end
        end
        res.right_column = COL_W'(bcol);
        res.right_peak   = PEAK_W'(best);

        for (c = 0; c < FRAME_COLUMNS; c++) lane_hist[c] = '0;
        return 1'b1;
    endfunction

    // Offer one pixel after a random gap and hold it until the transfer.
    // A typed expectation replaces the predicted one; the model still advances.
    task automatic push_pixel(input t_in_item it, input bit typed, input t_out_item want);
        t_out_item pred;
        @(negedge i_clk);
        while ($urandom_range(99) < idle_pct(run_mode, 1'b1)) begin
            r_valid <= 1'b0;
            @(negedge i_clk);
        end
        r_valid   <= 1'b1;
        r_in_item <= it;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        pixels_sent++;
        if (predict_peaks(it, pred)) begin
            peak_expect_q.insert(peak_expect_q.size(), typed ? want : pred);
        end
    endtask

    // Drop valid, wait for every pending result, then let the block go quiet
    task automatic settle_results(input int quiet);
        int waited;
        @(negedge i_clk);
        r_valid <= 1'b0;
        waited = 0;
        while (peak_expect_q.size() != 0 && waited < DRAIN_LIMIT) begin
            @(negedge i_clk);
            waited++;
        end
        if (peak_expect_q.size() != 0) begin
            report_mismatch($sformatf("%0d peak results never arrived", peak_expect_q.size()));
            peak_expect_q.delete();
        end
        repeat (quiet) @(negedge i_clk);
    endtask

    // Write one register; the block must be idle
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        r_cfg_we    <= 1'b1;
        r_cfg_index <= idx;
        r_cfg_data  <= data;
        @(negedge i_clk);
        r_cfg_we    <= 1'b0;
        if (idx == REG_MATCH_VALUE) cur_match = data[PIX_W-1:0];
        else                        cur_split = data[COL_W-1:0];
    endtask

    // One random frame: three hot columns, often near the split or the edges, collect
    // most pixels so that ties are common; some pixels miss or fall off the frame.
    task automatic send_frame(output int n_items);
        logic [COL_W-1:0] hot [3];
        t_in_item         it;
        int               len;
        int               k;
        len = $urandom_range(1, 24);
        for (k = 0; k < 3; k++) begin
            case ($urandom_range(5))
                0:       hot[k] = COL_W'(cur_split - 1);
                1:       hot[k] = cur_split;
                2:       hot[k] = '0;
                3:       hot[k] = COL_W'(FRAME_COLUMNS - 1);
                4:       hot[k] = COL_W'($urandom_range(FRAME_COLUMNS - 1));
                default: hot[k] = COL_W'($urandom_range(2047));
            endcase
        end
        for (k = 0; k < len; k++) begin
            it.column      = ($urandom_range(9) == 0) ? COL_W'($urandom_range(2047))
                                                      : hot[$urandom_range(2)];
            it.pixel_value = ($urandom_range(3) != 0) ? cur_match : PIX_W'($urandom);
            it.frame_end   = (k == len - 1);
            push_pixel(it, 1'b0, '0);
        end
        frames_sent++;
        n_items = len;
    endtask

    // Directed table helpers
    function automatic void add_pixel_row(input logic [PIX_W-1:0] pix,
                                          input logic [COL_W-1:0] col, input logic fend);
        t_stim_row row;
        row      = '0;
        row.kind = ROW_PIXEL;
        row.item = '{pixel_value: pix, column: col, frame_end: fend};
        stim_rows.insert(stim_rows.size(), row);
    endfunction

    function automatic void add_typed_row(input logic [PIX_W-1:0] pix,
                                          input logic [COL_W-1:0] col,
                                          input logic [COL_W-1:0] lc, input logic [COL_W-1:0] rc,
                                          input logic [PEAK_W-1:0] lp,
                                          input logic [PEAK_W-1:0] rp);
        t_stim_row row;
        row       = '0;
        row.kind  = ROW_PIXEL;
        row.item  = '{pixel_value: pix, column: col, frame_end: 1'b1};
        row.typed = 1'b1;
        row.want  = '{left_column: lc, right_column: rc, left_peak: lp, right_peak: rp};
        stim_rows.insert(stim_rows.size(), row);
    endfunction

    function automatic void add_write_row(input logic [CFG_IDX_W-1:0] idx,
                                          input logic [CFG_DATA_W-1:0] data);
        t_stim_row row;
        row           = '0;
        row.kind      = ROW_WRITE;
        row.reg_index = idx;
        row.reg_data  = data;
        stim_rows.insert(stim_rows.size(), row);
    endfunction

    // Receiver: drive ready at the falling edge; the long hold-off is counted here
    always @(negedge i_clk) begin
        if (hold_req && !hold_taken) begin
            hold_taken = 1'b1;
            hold_left  = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            r_ready <= 1'b0;
        end else begin
            r_ready <= ($urandom_range(99) >= idle_pct(run_mode, 1'b0));
        end
    end

    // Result checker: compare each transfer field by field with the oldest expectation
    always @(posedge i_clk) begin
        t_out_item want;
        if (r_rst_n && o_valid && r_ready) begin
            results_seen++;
            if (peak_expect_q.size() == 0) begin
                report_mismatch($sformatf("unexpected result %p", o_data));
            end else begin
                want = peak_expect_q.pop_front();
                if (o_data.left_column !== want.left_column)
                    report_mismatch($sformatf("left_column got %0d want %0d",
                                              o_data.left_column, want.left_column));
                if (o_data.right_column !== want.right_column)
                    report_mismatch($sformatf("right_column got %0d want %0d",
                                              o_data.right_column, want.right_column));
                if (o_data.left_peak !== want.left_peak)
                    report_mismatch($sformatf("left_peak got %0d want %0d",
                                              o_data.left_peak, want.left_peak));
                if (o_data.right_peak !== want.right_peak)
                    report_mismatch($sformatf("right_peak got %0d want %0d",
                                              o_data.right_peak, want.right_peak));
            end
        end
    end

    // Main stimulus
    initial begin
        int       ph;
        int       n;
        int       phase_items;
        int       phase_frames;

        // Reset state: nothing matches yet, so the top column of each half wins
        add_typed_row(8'd0, 11'd0, 11'd639, 11'd1279, 10'd0, 10'd0);
        // Edges of the frame, an off-frame column, a near miss, both sides of the split
        add_pixel_row(8'd255, 11'd0, 1'b0);
        add_pixel_row(8'd255, 11'd1279, 1'b0);
        add_pixel_row(8'd255, 11'd2047, 1'b0);
        add_pixel_row(8'd254, 11'd5, 1'b0);
        add_pixel_row(8'd255, 11'd639, 1'b0);
        add_pixel_row(8'd255, 11'd640, 1'b0);
        add_pixel_row(8'd255, 11'd1279, 1'b1);
        // Empty left half; frame end on an off-frame column still scans
        add_write_row(REG_MATCH_VALUE, 11'd0);
        add_write_row(REG_SPLIT_COLUMN, 11'd0);
        add_pixel_row(8'd0, 11'd100, 1'b0);
        add_typed_row(8'd0, 11'd2047, 11'd0, 11'd100, 10'd0, 10'd1);
        // Empty right half
        add_write_row(REG_MATCH_VALUE, 11'd128);
        add_write_row(REG_SPLIT_COLUMN, 11'd2047);
        add_typed_row(8'd128, 11'd1279, 11'd1279, 11'd1279, 10'd1, 10'd0);
        // Smallest split
        add_write_row(REG_MATCH_VALUE, 11'd255);
        add_write_row(REG_SPLIT_COLUMN, 11'd1);
        add_typed_row(8'd255, 11'd0, 11'd0, 11'd1279, 10'd1, 10'd0);
        // Largest in-range split, then a tie in the left half
        add_write_row(REG_SPLIT_COLUMN, 11'd1279);
        add_pixel_row(8'd255, 11'd1278, 1'b0);
        add_pixel_row(8'd255, 11'd1279, 1'b0);
        add_typed_row(8'd170, 11'd1365, 11'd1278, 11'd1279, 10'd1, 10'd1);
        add_pixel_row(8'd255, 11'd0, 1'b0);
        add_pixel_row(8'd255, 11'd1277, 1'b0);
        add_pixel_row(8'd85, 11'd1279, 1'b1);

        // Hold reset, then release at a falling edge
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        r_rst_n <= 1'b1;

        // Walk the directed table
        foreach (stim_rows[k]) begin
            if (stim_rows[k].kind == ROW_WRITE) begin
                settle_results(SETTLE_CYCLES);
                write_reg(stim_rows[k].reg_index, stim_rows[k].reg_data);
            end else begin
                push_pixel(stim_rows[k].item, stim_rows[k].typed, stim_rows[k].want);
            end
        end

        // Random phases, one idling mode each, new register settings between them
        for (ph = 0; ph < 4; ph++) begin
            settle_results(SETTLE_CYCLES);
            run_mode = IDLE_NONE;
            case (ph)
                0: begin
                    write_reg(REG_MATCH_VALUE, CFG_DATA_W'(MATCH_VALUE_RST));
                    write_reg(REG_SPLIT_COLUMN, CFG_DATA_W'(SPLIT_COLUMN_RST));
                end
                1: begin
                    write_reg(REG_MATCH_VALUE, CFG_DATA_W'($urandom_range(255)));
                    write_reg(REG_SPLIT_COLUMN, CFG_DATA_W'($urandom_range(1, FRAME_COLUMNS - 1)));
                end
                2: begin
                    write_reg(REG_MATCH_VALUE, '0);
                    write_reg(REG_SPLIT_COLUMN, CFG_DATA_W'(1));
                end
                default: begin
                    write_reg(REG_MATCH_VALUE, CFG_DATA_W'($urandom_range(255)));
                    write_reg(REG_SPLIT_COLUMN, CFG_DATA_W'(FRAME_COLUMNS - 1));
                end
            endcase
            case (ph)
                0:       run_mode = IDLE_NONE;
                1:       run_mode = IDLE_SENDER;
                2:       run_mode = IDLE_RECEIVER;
                default: run_mode = IDLE_BOTH;
            endcase

            // Start the long hold-off; keep offering frames so the block backs up
            if (ph == 0) hold_req = 1'b1;

            phase_items  = 0;
            phase_frames = 0;
            while (phase_items < PHASE_ITEMS || phase_frames < PHASE_FRAMES) begin
                send_frame(n);
                phase_items += n;
                phase_frames++;
                // Pause the sender until every pending result is back
                if (ph == 1 && phase_frames == PHASE_FRAMES / 2) settle_results(0);
            end
        end

        // Wait for the tail, then a full scan's worth of quiet to catch stray results
        settle_results(FRAME_COLUMNS + SETTLE_CYCLES);

        $display("ran %0d frames / %0d pixel transfers under four idling modes", frames_sent,
                 pixels_sent);
        $display("checked %0d peak results, incl. empty halves, ties and off-frame columns",
                 results_seen);
        if (mismatch_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("%0d mismatches", mismatch_count);
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
sv/chpf_pkg.sv
sv/chpf_ram.sv
sv/chpf_front.sv
sv/chpf_back.sv
sv/column_histogram_peak_finder.sv
tb/sv/tb.sv
